FILE: sv/sbr_pkg.sv
// sbr_pkg: shared types and constants of the stream byte reassembler.
// No dependencies.
`timescale 1ns / 1ps

package sbr_pkg;

    localparam int WINDOW_DEF = 64;
    localparam int IDX_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DATA,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_EOS  = 1'b1
    } t_kind;

endpackage

FILE: sv/stream_byte_reassembler.sv
// stream_byte_reassembler: ring-buffer reassembly of out-of-order stream bytes.
// Depends on sbr_pkg.
`timescale 1ns / 1ps

// Usage
//   Input transfer: start high while busy is low. A data item (kind 0) stores
//   its byte when byte_index lies in the window [ack, ack + WINDOW); it gives
//   no result and keeps busy high for one cycle. An end-of-segment item
//   (kind 1) scans the ring from the head, one slot a cycle, for up to
//   out_space contiguous valid bytes (out_space capped at WINDOW), then reads
//   the byte memory one slot a cycle to release them. Results appear on
//   o_strobe, one per cycle, the first one passing through the emit state and
//   the strobe register after the scan ends; if no byte is released, a single
//   status result follows the scan. o_last marks the final result of the
//   item. All results of one item carry the status after the release.
//   The receiver cannot stall: every strobed result is a completed transfer.
//   The scan and the single-port byte memory set the rate.
//   Reset (synchronous, active low) clears all valid bits, the ack position,
//   the pending count and the eof/end flags.

module stream_byte_reassembler #(
    parameter int WINDOW = sbr_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_kind,
    input  logic [sbr_pkg::IDX_W-1:0]   i_byte_index,
    input  logic [sbr_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_eof_flag,
    input  logic [sbr_pkg::CNT_W-1:0]   i_out_space,
    output logic                        o_strobe,
    output logic [sbr_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_byte_valid,
    output logic [sbr_pkg::IDX_W-1:0]   o_ack_pos,
    output logic [sbr_pkg::CNT_W-1:0]   o_unassembled_count,
    output logic                        o_stream_ended,
    output logic                        o_last
);
    import sbr_pkg::*;

    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW);
    localparam logic [IDX_W-1:0] WIN_IDX  = IDX_W'(WINDOW);
    localparam logic [PTR_W:0]   WIN_SUM  = (PTR_W + 1)'(WINDOW);

    logic [BYTE_W-1:0] mem [WINDOW];

    t_state r_state, n_state;

    logic [WINDOW-1:0] r_slot_valid;
    logic [IDX_W-1:0]  r_next_index;
    logic [CNT_W-1:0]  r_pending;
    logic              r_eof_seen;
    logic              r_ended;
    logic [PTR_W-1:0]  r_head;

    logic [IDX_W-1:0]  r_idx;
    logic [BYTE_W-1:0] r_byte;
    logic [CNT_W-1:0]  r_space;
    logic [CNT_W-1:0]  r_cnt;
    logic [PTR_W-1:0]  r_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;

    logic              r_strobe;
    logic              r_byte_valid;
    logic              r_last;
    logic [BYTE_W-1:0] r_out_byte;

    logic              accept;
    logic              scan_more;
    logic              scan_done;
    logic              emit;
    logic              status_only;
    logic [IDX_W-1:0]  offset;
    logic              in_window;
    logic [PTR_W:0]    slot_sum;
    logic [PTR_W-1:0]  wr_slot;
    logic [CNT_W-1:0]  pending_after;

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        ring_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign accept        = start && (r_state == ST_IDLE);
    assign offset        = r_idx - r_next_index;
    assign in_window     = offset < WIN_IDX;
    assign slot_sum      = {1'b0, r_head} + {1'b0, offset[PTR_W-1:0]};
    assign wr_slot       = (slot_sum >= WIN_SUM) ? PTR_W'(slot_sum - WIN_SUM)
                                                 : slot_sum[PTR_W-1:0];
    assign pending_after = r_pending - r_cnt;

    always_comb begin
        n_state     = r_state;
        scan_more   = 1'b0;
        scan_done   = 1'b0;
        emit        = 1'b0;
        status_only = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_kind == KIND_EOS) ? ST_SCAN : ST_DATA;
                end
            end
            ST_DATA: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if ((r_cnt < r_space) && r_slot_valid[r_ptr]) begin
                    scan_more = 1'b1;
                end else begin
                    scan_done = 1'b1;
                    if (r_cnt == '0) begin
                        status_only = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                emit = 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_next_index <= '0;
            r_pending    <= '0;
            r_eof_seen   <= 1'b0;
            r_ended      <= 1'b0;
            r_head       <= '0;
            r_cnt        <= '0;
            r_strobe     <= 1'b0;
            r_byte_valid <= 1'b0;
            r_last       <= 1'b0;
        end else begin
            r_strobe     <= emit || status_only;
            r_byte_valid <= emit;
            r_last       <= status_only || (emit && (r_cnt == CNT_W'(1)));
            if (accept) begin
                r_cnt <= '0;
                if (i_kind == KIND_EOS && i_eof_flag) begin
                    r_eof_seen <= 1'b1;
                end
            end
            if (r_state == ST_DATA && in_window && !r_slot_valid[wr_slot]) begin
                r_slot_valid[wr_slot] <= 1'b1;
                r_pending             <= r_pending + 1'b1;
            end
            if (scan_more) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (scan_done) begin
                r_head       <= r_ptr;
                r_next_index <= r_next_index + IDX_W'(r_cnt);
                r_pending    <= pending_after;
                if (r_eof_seen && pending_after == '0) begin
                    r_ended <= 1'b1;
                end
            end
            if (emit) begin
                r_slot_valid[r_rd_ptr] <= 1'b0;
                r_cnt                  <= r_cnt - 1'b1;
            end
        end
    end

    // payload and pointers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx    <= i_byte_index;
            r_byte   <= i_data_byte;
            r_space  <= (i_out_space > WIN_CNT) ? WIN_CNT : i_out_space;
            r_ptr    <= r_head;
            r_rd_ptr <= r_head;
        end
        if (scan_more) begin
            r_ptr <= ring_inc(r_ptr);
        end
        if (emit) begin
            r_rd_ptr <= ring_inc(r_rd_ptr);
        end
    end

    // byte memory
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DATA && in_window) begin
            mem[wr_slot] <= r_byte;
        end
        if (emit) begin
            r_out_byte <= mem[r_rd_ptr];
        end else if (status_only) begin
            r_out_byte <= '0;
        end
    end

    assign busy                = (r_state != ST_IDLE);
    assign o_strobe            = r_strobe;
    assign o_out_byte          = r_out_byte;
    assign o_byte_valid        = r_byte_valid;
    assign o_ack_pos           = r_next_index;
    assign o_unassembled_count = r_pending;
    assign o_stream_ended      = r_ended;
    assign o_last              = r_last;

endmodule

FILE: sv/sbr_checker.sv
// sbr_checker: port-level assertions for stream_byte_reassembler, and its bind.
// Depends on sbr_pkg.
`timescale 1ns / 1ps

module sbr_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        o_strobe,
    input  logic                        o_byte_valid,
    input  logic [sbr_pkg::IDX_W-1:0]   o_ack_pos,
    input  logic                        o_last
);
    import sbr_pkg::*;

    a_last_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_strobe)
        else $error("last without strobe");

    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_byte_valid) |-> o_last)
        else $error("status-only result not marked last");

    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside a result burst");

    a_status_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> $stable(o_ack_pos))
        else $error("ack position changed within one item");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after input transfer");

endmodule

bind stream_byte_reassembler sbr_checker u_sbr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_byte_valid (o_byte_valid),
    .o_ack_pos    (o_ack_pos),
    .o_last       (o_last)
);

FILE: tb/tb_top.sv
// tb_top: self-checking testbench of stream_byte_reassembler (window reassembly, release order).
// Depends on sbr_pkg and stream_byte_reassembler; checks every strobed result in order
// against a behavioral prediction kept in a small scoreboard class.
`timescale 1ns / 1ps

module tb_top;

    localparam int WIN       = sbr_pkg::WINDOW_DEF;
    localparam int LIMIT     = 300000;
    localparam int RAND_ENDS = 150;

    typedef struct {
        sbr_pkg::t_kind kind;
        logic [31:0]    idx;
        logic [7:0]     data;
        logic           eof;
        logic [6:0]     space;
    } t_item;

    typedef struct {
        logic [7:0]  data;
        logic        valid;
        logic [31:0] ack;
        logic [6:0]  pend;
        logic        ended;
        logic        last;
    } t_release;

    class t_reassembly_board;
        logic [7:0]  ring_byte [WIN];
        bit          ring_full [WIN];
        logic [31:0] ack_idx;
        int          pend;
        int          head;
        bit          eof_seen;
        bit          ended;
        t_release    release_q [$];
        int          errors;
        int          checked;
        int          bytes_out;

        function new();
            ack_idx   = '0;
            pend      = 0;
            head      = 0;
            eof_seen  = 0;
            ended     = 0;
            errors    = 0;
            checked   = 0;
            bytes_out = 0;
            foreach (ring_full[i]) ring_full[i] = 0;
        endfunction

        function bit held(int off);
            return ring_full[(head + off) % WIN];
        endfunction

        function void take_item(t_item it);
            logic [31:0] offset;
            logic [7:0]  out_b [WIN];
            int          lim;
            int          n;
            int          s;
            int          cnt;
            t_release    r;
            n = 0;
            if (it.kind == sbr_pkg::KIND_DATA) begin
                offset = it.idx - ack_idx;
                if (offset < 32'(WIN)) begin
                    s = (head + int'(offset)) % WIN;
                    ring_byte[s] = it.data;
                    if (!ring_full[s]) begin
                        ring_full[s] = 1;
                        pend++;
                    end
                end
                return;
            end
            if (it.eof) eof_seen = 1;
            lim = (int'(it.space) > WIN) ? WIN : int'(it.space);
            while (n < lim && ring_full[head]) begin
                out_b[n] = ring_byte[head];
                ring_full[head] = 0;
                n++;
                pend--;
                ack_idx++;
                head = (head + 1) % WIN;
            end
            if (eof_seen && pend == 0) ended = 1;
            cnt = (n == 0) ? 1 : n;
            for (int k = 0; k < cnt; k++) begin
                r.data  = (n == 0) ? 8'h00 : out_b[k];
                r.valid = (n != 0);
                r.ack   = ack_idx;
                r.pend  = 7'(pend);
                r.ended = ended;
                r.last  = (k == cnt - 1);
                release_q.push_back(r);
            end
        endfunction

        function bit same(string fname, logic [31:0] e, logic [31:0] a);
            if (a !== e) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, e, a);
                return 0;
            end
            return 1;
        endfunction

        function void check_release(t_release got);
            t_release e;
            if (release_q.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected result, got byte %0h valid %0b ack %0h last %0b",
                             $time, got.data, got.valid, got.ack, got.last);
                return;
            end
            e = release_q.pop_front();
            checked++;
            if (e.valid) bytes_out++;
            void'(same("out_byte", 32'(e.data), 32'(got.data)));
            void'(same("byte_valid", 32'(e.valid), 32'(got.valid)));
            void'(same("ack_pos", e.ack, got.ack));
            void'(same("unassembled_count", 32'(e.pend), 32'(got.pend)));
            void'(same("stream_ended", 32'(e.ended), 32'(got.ended)));
            void'(same("last", 32'(e.last), 32'(got.last)));
        endfunction
    endclass

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    logic       i_kind       = 1'b0;
    logic [31:0] i_byte_index = '0;
    logic [7:0] i_data_byte  = '0;
    logic       i_eof_flag   = 1'b0;
    logic [6:0] i_out_space  = '0;
    logic       o_strobe;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic [31:0] o_ack_pos;
    logic [6:0] o_unassembled_count;
    logic       o_stream_ended;
    logic       o_last;

    t_reassembly_board sb = new();
    int cycles       = 0;
    int accepted_cnt = 0;
    int sent_cnt     = 0;
    int idle_pct     = 24;

    stream_byte_reassembler dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_kind              (i_kind),
        .i_byte_index        (i_byte_index),
        .i_data_byte         (i_data_byte),
        .i_eof_flag          (i_eof_flag),
        .i_out_space         (i_out_space),
        .o_strobe            (o_strobe),
        .o_out_byte          (o_out_byte),
        .o_byte_valid        (o_byte_valid),
        .o_ack_pos           (o_ack_pos),
        .o_unassembled_count (o_unassembled_count),
        .o_stream_ended      (o_stream_ended),
        .o_last              (o_last)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("stream_byte_reassembler regression: fail");
            $finish;
        end
    end

    // results first, then the transfer taken at this edge
    always @(posedge i_clk) begin
        t_release got;
        t_item    it;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                got.data  = o_out_byte;
                got.valid = o_byte_valid;
                got.ack   = o_ack_pos;
                got.pend  = o_unassembled_count;
                got.ended = o_stream_ended;
                got.last  = o_last;
                sb.check_release(got);
            end
            if (start && busy === 1'b0) begin
                it.kind  = sbr_pkg::t_kind'(i_kind);
                it.idx   = i_byte_index;
                it.data  = i_data_byte;
                it.eof   = i_eof_flag;
                it.space = i_out_space;
                sb.take_item(it);
                accepted_cnt++;
            end
        end
    end

    task automatic drive_item(t_item it);
        int gap = 0;
        while (gap < 16 && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_kind       <= it.kind;
        i_byte_index <= it.idx;
        i_data_byte  <= it.data;
        i_eof_flag   <= it.eof;
        i_out_space  <= it.space;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sent_cnt++;
        wait (accepted_cnt == sent_cnt);
    endtask

    task automatic drive_data(logic [31:0] idx, logic [7:0] data);
        t_item it;
        it.kind  = sbr_pkg::KIND_DATA;
        it.idx   = idx;
        it.data  = data;
        it.eof   = 1'($urandom_range(1));
        it.space = 7'($urandom_range(127));
        drive_item(it);
    endtask

    task automatic drive_eos(logic eof, logic [6:0] space);
        t_item it;
        it.kind  = sbr_pkg::KIND_EOS;
        it.idx   = $urandom();
        it.data  = 8'($urandom());
        it.eof   = eof;
        it.space = space;
        drive_item(it);
    endtask

    task automatic run_segment();
        logic [31:0] ack;
        logic [31:0] idx;
        int          len;
        int          base;
        int          order;
        int          off;
        ack   = sb.ack_idx;
        len   = ($urandom_range(15) == 0) ? WIN : $urandom_range(1, 12);
        base  = (len == WIN || $urandom_range(1) == 0) ? 0 : $urandom_range(1, 20);
        order = $urandom_range(2);
        for (int k = 0; k < len; k++) begin
            case (order)
                0:       off = base + k;
                1:       off = base + len - 1 - k;
                default: off = base + $urandom_range(0, len - 1);
            endcase
            idx = ack + 32'(off);
            if ($urandom_range(99) < 12) begin
                case ($urandom_range(2))
                    0:       idx = $urandom();
                    1:       idx = ack - 32'd1 - 32'($urandom_range(0, 200));
                    default: idx = ack + 32'(WIN) + 32'($urandom_range(0, 1000));
                endcase
            end
            drive_data(idx, 8'($urandom()));
        end
        if ($urandom_range(9) == 0)
            drive_eos(1'b0, 7'($urandom_range(65, 127)));
        else
            drive_eos(1'b0, 7'($urandom_range(0, 64)));
    endtask

    initial begin
        int top;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty window, ring edges, out-of-window drops, duplicate, release limits
        drive_eos(1'b0, 7'd0);
        drive_data(32'd0, 8'h00);
        drive_data(32'd1, 8'hFF);
        drive_data(32'd63, 8'hA5);
        drive_data(32'd64, 8'h11);
        drive_data(32'hFFFF_FFFF, 8'h22);
        drive_data(32'd1, 8'h5A);
        drive_eos(1'b0, 7'd0);
        drive_eos(1'b0, 7'd1);
        drive_eos(1'b0, 7'd127);
        drive_data(32'd0, 8'h77);
        drive_data(32'd65, 8'h80);
        drive_data(32'd2, 8'hC3);
        drive_eos(1'b0, 7'd64);
        drive_data(32'd3, 8'h3C);
        drive_eos(1'b0, 7'd65);

        while (sent_cnt < RAND_ENDS) begin
            idle_pct = (sent_cnt < 60) ? 24 : (sent_cnt < 110) ? 58 : 0;
            run_segment();
        end

        // end of stream: eof with holes, fill them, drain, then traffic after the end
        drive_eos(1'b1, 7'd0);
        top = -1;
        for (int off = 0; off < WIN; off++)
            if (sb.held(off)) top = off;
        for (int off = 0; off <= top; off++)
            if (!sb.held(off)) drive_data(sb.ack_idx + 32'(off), 8'($urandom()));
        drive_eos(1'b0, 7'd64);
        drive_data(sb.ack_idx + 32'd5, 8'($urandom()));
        drive_eos(1'b1, 7'd127);
        start <= 1'b0;

        while (sb.release_q.size() != 0) @(posedge i_clk);
        repeat (2 * WIN + 8) @(posedge i_clk);

        $display("%0d transfers in, %0d results checked, %0d bytes released in order",
                 sent_cnt, sb.checked, sb.bytes_out);
        $display("final ack position %0h, stream ended %0b, %0d mismatches",
                 sb.ack_idx, sb.ended, sb.errors);
        if (sb.errors == 0 && sb.release_q.size() == 0)
            $display("stream_byte_reassembler regression: pass");
        else
            $display("stream_byte_reassembler regression: fail");
        $finish;
    end

endmodule
